[src/xmbs_pkg.sv]
// Package for the XMODEM block sender: operation codes, protocol bytes,
// session and frame phase codes, and the per-byte CRC-16 update.
// No dependencies.
package xmbs_pkg;

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_HOST    = 3'd1;
    localparam logic [2:0] OP_PARTNER = 3'd2;
    localparam logic [2:0] OP_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_CLOSE   = 3'd4;
    localparam logic [2:0] OP_SLOT    = 3'd5;

    localparam logic [7:0] CH_SOH   = 8'h01;
    localparam logic [7:0] CH_STX   = 8'h02;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_NAK   = 8'h15;
    localparam logic [7:0] CH_CAN   = 8'h18;
    localparam logic [7:0] CH_GOCRC = 8'h43;

    localparam logic [2:0] CAN_COUNT = 3'd5;
    localparam logic [2:0] EOT_DONE  = 3'd4;

    localparam logic [3:0] PH_WAIT      = 4'd0;
    localparam logic [3:0] PH_COLLECT   = 4'd1;
    localparam logic [3:0] PH_TX        = 4'd2;
    localparam logic [3:0] PH_REPLY     = 4'd3;
    localparam logic [3:0] PH_CLOSING   = 4'd4;
    localparam logic [3:0] PH_DONE      = 4'd5;
    localparam logic [3:0] PH_FAILED    = 4'd6;
    localparam logic [3:0] PH_START_TO  = 4'd7;
    localparam logic [3:0] PH_START_CAN = 4'd8;

    localparam logic [2:0] FP_HEADER = 3'd0;
    localparam logic [2:0] FP_BLKNUM = 3'd1;
    localparam logic [2:0] FP_BLKINV = 3'd2;
    localparam logic [2:0] FP_DATA   = 3'd3;
    localparam logic [2:0] FP_CHECK  = 3'd4;
    localparam logic [2:0] FP_CRC_LO = 3'd5;

    localparam logic [3:0] RETRY_RESET = 4'd8;
    localparam logic       CFG_LARGE_BLOCKS = 1'b0;
    localparam logic       CFG_RETRY_LIMIT  = 1'b1;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[src/xmodem_block_sender.sv]
// XMODEM block sender top level: session control, framing, checksum/CRC and
// the block buffer memory. Depends on xmbs_pkg.
//
// Channel   Direction  Handshake           Word
// s_        in         s_valid / s_ready   opcode, data_byte, abort_flag
// m_        out        m_valid / m_ready   tx_valid, tx_byte, accepted, status, block
// cfg_      in         cfg_wr_en           cfg_addr, cfg_wdata
//
// One word is taken per cycle while the output register is not stalled; its result
// appears in the output register on the next cycle, and a new word is taken while
// that result is being drained. The block buffer is read ahead at the next send
// position, with a bypass for a write to the same entry. Reset does not clear the
// buffer. A stalled output register holds s_ready low until it is taken.
module xmodem_block_sender #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_opcode,
    input  logic [7:0] s_data_byte,
    input  logic       s_abort_flag,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_byte,
    output logic       m_accepted,
    output logic [3:0] m_status,
    output logic [7:0] m_current_block,
    input  logic       cfg_wr_en,
    input  logic       cfg_addr,
    input  logic [3:0] cfg_wdata
);
    import xmbs_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int SPW = $clog2(BUFFER_BYTES + 1);
    localparam int LARGE_LEN = (BUFFER_BYTES >= 1024) ? 1024 : 128;
    localparam logic [SPW-1:0] LEN_SMALL = SPW'(128);
    localparam logic [SPW-1:0] LEN_LARGE = SPW'(LARGE_LEN);
    localparam logic [SPW-1:0] BUF_DEPTH = SPW'(BUFFER_BYTES);

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] buf_rd_reg;
    logic [7:0] fwd_data_reg;
    logic       fwd_hit_reg;
    logic [7:0] buf_rd;
    logic       buf_we;
    logic [AW-1:0] buf_wa;
    logic [AW-1:0] buf_ra;

    logic           cfg_large_reg;
    logic [3:0]     cfg_retry_reg;
    logic [3:0]     phase_reg, phase_next;
    logic [2:0]     frame_reg, frame_next;
    logic [2:0]     seq_reg, seq_next;
    logic [SPW-1:0] fill_reg, fill_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [7:0]     blk_reg, blk_next;
    logic           crc_mode_reg, crc_mode_next;
    logic [15:0]    crc_reg, crc_next;
    logic [7:0]     sum_reg, sum_next;
    logic [3:0]     retries_reg, retries_next;
    logic           err_reg, err_next;
    logic           last_reg, last_next;
    logic           cancel_reg, cancel_next;
    logic           large_reg, large_next;

    logic           m_valid_reg;
    logic           tx_valid_reg, tx_valid_next;
    logic [7:0]     tx_byte_reg, tx_byte_next;
    logic           accepted_reg, accepted_next;
    logic [3:0]     status_reg;
    logic [7:0]     block_out_reg;

    logic           s_fire;
    logic           use_large;
    logic [SPW-1:0] blk_len;
    logic [SPW-1:0] fill_inc;
    logic [SPW-1:0] sp_inc;
    logic [7:0]     data_sel;
    logic           do_fail;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire = s_valid && s_ready;
    assign use_large = large_reg && (BUFFER_BYTES >= 1024);
    assign blk_len = use_large ? LEN_LARGE : LEN_SMALL;
    assign fill_inc = fill_reg + SPW'(1);
    assign sp_inc = sp_reg + SPW'(1);
    assign buf_rd = fwd_hit_reg ? fwd_data_reg : buf_rd_reg;
    assign data_sel = (sp_reg < fill_reg && sp_reg < BUF_DEPTH) ? buf_rd : 8'h00;
    assign buf_wa = fill_reg[AW-1:0];
    assign buf_ra = sp_next[AW-1:0];

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            mem[buf_wa] <= s_data_byte;
        end
        buf_rd_reg <= mem[buf_ra];
        fwd_hit_reg <= buf_we && (buf_wa == buf_ra);
        fwd_data_reg <= s_data_byte;
    end

    always_comb begin
        phase_next = phase_reg;
        frame_next = frame_reg;
        seq_next = seq_reg;
        fill_next = fill_reg;
        sp_next = sp_reg;
        blk_next = blk_reg;
        crc_mode_next = crc_mode_reg;
        crc_next = crc_reg;
        sum_next = sum_reg;
        retries_next = retries_reg;
        err_next = err_reg;
        last_next = last_reg;
        cancel_next = cancel_reg;
        large_next = large_reg;
        buf_we = 1'b0;
        do_fail = 1'b0;
        tx_valid_next = 1'b0;
        tx_byte_next = 8'h00;
        accepted_next = 1'b0;
        if (s_fire) begin
            unique case (s_opcode)
                OP_START: begin
                    fill_next = '0;
                    sp_next = '0;
                    frame_next = FP_HEADER;
                    phase_next = PH_WAIT;
                    blk_next = 8'd1;
                    crc_mode_next = 1'b0;
                    crc_next = 16'h0000;
                    sum_next = 8'h00;
                    retries_next = cfg_retry_reg;
                    seq_next = 3'd0;
                    err_next = 1'b0;
                    last_next = 1'b0;
                    cancel_next = 1'b0;
                    large_next = cfg_large_reg;
                end
                OP_HOST: begin
                    if (phase_reg == PH_COLLECT && fill_reg < BUF_DEPTH) begin
                        buf_we = 1'b1;
                        fill_next = fill_inc;
                        accepted_next = 1'b1;
                        if (fill_inc >= blk_len) begin
                            phase_next = PH_TX;
                            frame_next = FP_HEADER;
                            sp_next = '0;
                            retries_next = cfg_retry_reg;
                        end
                    end
                end
                OP_PARTNER, OP_TIMEOUT: begin
                    if (phase_reg == PH_WAIT) begin
                        if (s_opcode == OP_TIMEOUT) begin
                            phase_next = PH_START_TO;
                        end else if (s_data_byte == CH_NAK) begin
                            crc_mode_next = 1'b0;
                            phase_next = PH_COLLECT;
                        end else if (s_data_byte == CH_GOCRC) begin
                            crc_mode_next = 1'b1;
                            phase_next = PH_COLLECT;
                        end else if (s_data_byte == CH_CAN) begin
                            phase_next = PH_START_CAN;
                        end
                    end else if (phase_reg == PH_REPLY) begin
                        if (s_opcode == OP_PARTNER && s_data_byte == CH_ACK) begin
                            blk_next = blk_reg + 8'd1;
                            fill_next = '0;
                            if (last_reg) begin
                                last_next = 1'b0;
                                phase_next = PH_CLOSING;
                                cancel_next = 1'b0;
                                seq_next = 3'd0;
                            end else begin
                                phase_next = PH_COLLECT;
                            end
                        end else if (s_opcode == OP_PARTNER && s_data_byte == CH_CAN) begin
                            do_fail = 1'b1;
                        end else if (retries_reg > 4'd1) begin
                            retries_next = retries_reg - 4'd1;
                            phase_next = PH_TX;
                            frame_next = FP_HEADER;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end else if (phase_reg == PH_CLOSING && !cancel_reg &&
                                 (seq_reg == 3'd1 || seq_reg == 3'd3)) begin
                        seq_next = seq_reg + 3'd1;
                        if (seq_reg + 3'd1 >= EOT_DONE) begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                OP_CLOSE: begin
                    if (phase_reg == PH_FAILED) begin
                        phase_next = PH_CLOSING;
                        cancel_next = 1'b1;
                        seq_next = 3'd0;
                    end else if (phase_reg == PH_COLLECT) begin
                        if (s_abort_flag || err_reg) begin
                            phase_next = PH_CLOSING;
                            cancel_next = 1'b1;
                            seq_next = 3'd0;
                        end else if (fill_reg != '0) begin
                            last_next = 1'b1;
                            phase_next = PH_TX;
                            frame_next = FP_HEADER;
                            sp_next = '0;
                            retries_next = cfg_retry_reg;
                        end else begin
                            phase_next = PH_CLOSING;
                            cancel_next = 1'b0;
                            seq_next = 3'd0;
                        end
                    end
                end
                OP_SLOT: begin
                    if (phase_reg == PH_TX) begin
                        tx_valid_next = 1'b1;
                        unique case (frame_reg)
                            FP_HEADER: begin
                                tx_byte_next = use_large ? CH_STX : CH_SOH;
                                crc_next = 16'h0000;
                                sum_next = 8'h00;
                                sp_next = '0;
                                frame_next = FP_BLKNUM;
                            end
                            FP_BLKNUM: begin
                                tx_byte_next = blk_reg;
                                frame_next = FP_BLKINV;
                            end
                            FP_BLKINV: begin
                                tx_byte_next = ~blk_reg;
                                frame_next = FP_DATA;
                            end
                            FP_DATA: begin
                                tx_byte_next = data_sel;
                                sum_next = sum_reg + data_sel;
                                crc_next = crc16_byte(crc_reg, data_sel);
                                sp_next = sp_inc;
                                if (sp_inc >= blk_len) begin
                                    frame_next = FP_CHECK;
                                end
                            end
                            FP_CHECK: begin
                                if (crc_mode_reg) begin
                                    tx_byte_next = crc_reg[15:8];
                                    frame_next = FP_CRC_LO;
                                end else begin
                                    tx_byte_next = sum_reg;
                                    frame_next = FP_HEADER;
                                    phase_next = PH_REPLY;
                                end
                            end
                            default: begin
                                tx_byte_next = crc_reg[7:0];
                                frame_next = FP_HEADER;
                                phase_next = PH_REPLY;
                            end
                        endcase
                    end else if (phase_reg == PH_CLOSING) begin
                        if (cancel_reg) begin
                            tx_valid_next = 1'b1;
                            tx_byte_next = CH_CAN;
                            seq_next = seq_reg + 3'd1;
                            if (seq_reg + 3'd1 >= CAN_COUNT) begin
                                phase_next = err_reg ? PH_FAILED : PH_DONE;
                            end
                        end else if (seq_reg == 3'd0 || seq_reg == 3'd2) begin
                            tx_valid_next = 1'b1;
                            tx_byte_next = CH_EOT;
                            seq_next = seq_reg + 3'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (do_fail) begin
                if (last_reg) begin
                    last_next = 1'b0;
                    phase_next = PH_CLOSING;
                    cancel_next = 1'b0;
                    seq_next = 3'd0;
                end else begin
                    phase_next = PH_FAILED;
                    err_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_large_reg <= 1'b1;
            cfg_retry_reg <= RETRY_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_LARGE_BLOCKS) begin
                cfg_large_reg <= cfg_wdata[0];
            end else begin
                cfg_retry_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            frame_reg <= FP_HEADER;
            seq_reg <= 3'd0;
            fill_reg <= '0;
            sp_reg <= '0;
            blk_reg <= 8'd1;
            crc_mode_reg <= 1'b0;
            crc_reg <= 16'h0000;
            sum_reg <= 8'h00;
            retries_reg <= RETRY_RESET;
            err_reg <= 1'b0;
            last_reg <= 1'b0;
            cancel_reg <= 1'b0;
            large_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            frame_reg <= frame_next;
            seq_reg <= seq_next;
            fill_reg <= fill_next;
            sp_reg <= sp_next;
            blk_reg <= blk_next;
            crc_mode_reg <= crc_mode_next;
            crc_reg <= crc_next;
            sum_reg <= sum_next;
            retries_reg <= retries_next;
            err_reg <= err_next;
            last_reg <= last_next;
            cancel_reg <= cancel_next;
            large_reg <= large_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            tx_valid_reg <= tx_valid_next;
            tx_byte_reg <= tx_byte_next;
            accepted_reg <= accepted_next;
            status_reg <= phase_next;
            block_out_reg <= blk_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_tx_valid = tx_valid_reg;
    assign m_tx_byte = tx_byte_reg;
    assign m_accepted = accepted_reg;
    assign m_status = status_reg;
    assign m_current_block = block_out_reg;

    a_host_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_opcode == OP_HOST && phase_reg == PH_COLLECT |=> m_valid && m_accepted)
        else $error("host byte in collecting phase was not stored");

    a_accept_no_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> !m_tx_valid)
        else $error("stored host byte result also carries a transmit byte");

    a_send_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= blk_len)
        else $error("send position ran past the block length");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_COLLECT |-> fill_reg < blk_len)
        else $error("full block still collecting");

endmodule
